/* sv/mfri_pkg.sv */
// Money flow ratio index: shared widths, constants and control structs.
// No dependencies; used by every module of the block.
`default_nettype none
package mfri_pkg;

  localparam int WINDOW  = 14;
  localparam int PRICE_W = 24;
  localparam int VOL_W   = 32;
  localparam int PSUM_W  = PRICE_W + 2;
  localparam int FLOW_W  = PSUM_W + VOL_W;
  localparam int IDX_W   = $clog2(WINDOW);
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = FLOW_W + $clog2(WINDOW);
  localparam int ADDR_W  = IDX_W + 1;

  localparam int INDEX_W   = 15;
  localparam int PCT_SCALE = 25600;
  // 25600 = 2^14 + 2^13 + 2^10
  localparam int PCT_SH0   = 14;
  localparam int PCT_SH1   = 13;
  localparam int PCT_SH2   = 10;
  localparam int NUM_W     = SUM_W + INDEX_W;
  localparam int STEP_W    = $clog2(INDEX_W);

  localparam int IN_W  = 3 * PRICE_W + VOL_W;
  localparam int OUT_W = ((INDEX_W + 7) / 8) * 8;

  typedef struct packed {
    logic valid;
    logic falling;
  } win_req_t;

  typedef struct packed {
    logic done;
    logic both_full;
  } win_status_t;

endpackage
`default_nettype wire

/* sv/mfri_window.sv */
// Rising and falling flow windows: one shared flow memory, counts, oldest slots, sums.
// Depends on mfri_pkg.
`default_nettype none
module mfri_window (
  input  logic                       clk,
  input  logic                       rst,
  input  mfri_pkg::win_req_t         req,
  input  logic [mfri_pkg::FLOW_W-1:0] flow,
  output mfri_pkg::win_status_t      status,
  output logic [mfri_pkg::SUM_W-1:0] rising_sum,
  output logic [mfri_pkg::SUM_W-1:0] falling_sum
);

  logic [mfri_pkg::FLOW_W-1:0] mem [0:(2**mfri_pkg::ADDR_W)-1];
  logic [mfri_pkg::FLOW_W-1:0] rd_data;
  logic [mfri_pkg::ADDR_W-1:0] rd_addr;

  logic                        upd_valid;
  logic                        upd_falling;
  logic [mfri_pkg::FLOW_W-1:0] upd_flow;
  logic                        done;

  logic [mfri_pkg::CNT_W-1:0] rising_count, falling_count;
  logic [mfri_pkg::IDX_W-1:0] rising_oldest, falling_oldest;

  logic [mfri_pkg::CNT_W-1:0] cur_count, count_next;
  logic [mfri_pkg::IDX_W-1:0] cur_oldest, oldest_next, wr_slot, fill_slot;
  logic [mfri_pkg::IDX_W:0]   fill_pos;
  logic [mfri_pkg::SUM_W-1:0] cur_sum, sum_next;
  logic                       is_full;

  assign rd_addr = {req.falling, req.falling ? falling_oldest : rising_oldest};

  always_comb begin
    cur_count  = upd_falling ? falling_count : rising_count;
    cur_oldest = upd_falling ? falling_oldest : rising_oldest;
    cur_sum    = upd_falling ? falling_sum : rising_sum;
    is_full    = (cur_count == mfri_pkg::CNT_W'(mfri_pkg::WINDOW));
    fill_pos   = (mfri_pkg::IDX_W + 1)'(cur_oldest) + (mfri_pkg::IDX_W + 1)'(cur_count);
    if (fill_pos >= (mfri_pkg::IDX_W + 1)'(mfri_pkg::WINDOW)) begin
      fill_slot = mfri_pkg::IDX_W'(fill_pos - (mfri_pkg::IDX_W + 1)'(mfri_pkg::WINDOW));
    end else begin
      fill_slot = fill_pos[mfri_pkg::IDX_W-1:0];
    end
    if (is_full) begin
      wr_slot    = cur_oldest;
      count_next = cur_count;
      sum_next   = cur_sum - mfri_pkg::SUM_W'(rd_data) + mfri_pkg::SUM_W'(upd_flow);
      if (cur_oldest == mfri_pkg::IDX_W'(mfri_pkg::WINDOW - 1)) begin
        oldest_next = '0;
      end else begin
        oldest_next = cur_oldest + 1'b1;
      end
    end else begin
      wr_slot     = fill_slot;
      count_next  = cur_count + 1'b1;
      sum_next    = cur_sum + mfri_pkg::SUM_W'(upd_flow);
      oldest_next = cur_oldest;
    end
  end

  // oldest entry is read while the update is staged, written back next cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (upd_valid) begin
      mem[{upd_falling, wr_slot}] <= upd_flow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid      <= 1'b0;
      done           <= 1'b0;
      rising_count   <= '0;
      falling_count  <= '0;
      rising_oldest  <= '0;
      falling_oldest <= '0;
      rising_sum     <= '0;
      falling_sum    <= '0;
    end else begin
      upd_valid <= req.valid;
      done      <= upd_valid;
      if (upd_valid) begin
        if (upd_falling) begin
          falling_count  <= count_next;
          falling_oldest <= oldest_next;
          falling_sum    <= sum_next;
        end else begin
          rising_count  <= count_next;
          rising_oldest <= oldest_next;
          rising_sum    <= sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      upd_falling <= req.falling;
      upd_flow    <= flow;
    end
  end

  always_comb begin
    status.done      = done;
    status.both_full = (rising_count == mfri_pkg::CNT_W'(mfri_pkg::WINDOW)) &&
                       (falling_count == mfri_pkg::CNT_W'(mfri_pkg::WINDOW));
  end

endmodule
`default_nettype wire

/* sv/mfri_divider.sv */
// Restoring divider, one quotient bit a cycle: floor(PCT_SCALE * p / (p + n)), 0 if p + n is 0.
// Depends on mfri_pkg.
`default_nettype none
module mfri_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mfri_pkg::SUM_W-1:0]   p,
  input  logic [mfri_pkg::SUM_W-1:0]   n,
  output logic                         done,
  output logic [mfri_pkg::INDEX_W-1:0] quotient
);

  logic                          busy;
  logic [mfri_pkg::STEP_W-1:0]   step;
  logic [mfri_pkg::SUM_W:0]      den;
  logic [mfri_pkg::SUM_W:0]      rem;
  logic [mfri_pkg::INDEX_W-1:0]  num_lo;
  logic [mfri_pkg::INDEX_W-1:0]  q;
  logic                          den_zero;

  logic [mfri_pkg::NUM_W-1:0]    num;
  logic [mfri_pkg::SUM_W:0]      den_in;
  logic [mfri_pkg::SUM_W+1:0]    trial;
  logic                          take;

  always_comb begin
    num = (mfri_pkg::NUM_W'(p) << mfri_pkg::PCT_SH0) +
          (mfri_pkg::NUM_W'(p) << mfri_pkg::PCT_SH1) +
          (mfri_pkg::NUM_W'(p) << mfri_pkg::PCT_SH2);
    den_in = (mfri_pkg::SUM_W + 1)'(p) + (mfri_pkg::SUM_W + 1)'(n);
    trial  = {rem, num_lo[mfri_pkg::INDEX_W-1]};
    take   = (trial >= (mfri_pkg::SUM_W + 2)'(den));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= mfri_pkg::STEP_W'(mfri_pkg::INDEX_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient is below 2^INDEX_W, so the upper numerator bits start below den
  always_ff @(posedge clk) begin
    if (start) begin
      den      <= den_in;
      den_zero <= (den_in == '0);
      rem      <= (mfri_pkg::SUM_W + 1)'(num[mfri_pkg::NUM_W-1:mfri_pkg::INDEX_W]);
      num_lo   <= num[mfri_pkg::INDEX_W-1:0];
      q        <= '0;
    end else if (busy) begin
      rem    <= take ? (mfri_pkg::SUM_W + 1)'(trial - (mfri_pkg::SUM_W + 2)'(den))
                     : (mfri_pkg::SUM_W + 1)'(trial);
      num_lo <= {num_lo[mfri_pkg::INDEX_W-2:0], 1'b0};
      q      <= {q[mfri_pkg::INDEX_W-2:0], take};
    end
  end

  assign quotient = den_zero ? '0 : q;

endmodule
`default_nettype wire

/* sv/money_flow_ratio_index_top.sv */
// Money flow ratio index top: flow multiply, sequencer, output register.
// Depends on mfri_pkg, mfri_window, mfri_divider.
// Path from input transfer to output valid: S_MUL, S_PUSH, S_WAIT when the flow changed,
// S_CHECK, S_DIV when both windows are full, then S_OUT, which waits on m_axis_tready.
// Throughput: one bar at a time; input is taken again only back in S_IDLE.
// Reset (rst, synchronous): counts, slots, sums, previous flow cleared, input held off.
`default_nettype none
module money_flow_ratio_index_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // high_price[23:0], low_price[47:24], close_price[71:48], volume[103:72]
  input  logic [mfri_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // index_value[14:0], zero padding above
  output logic [mfri_pkg::OUT_W-1:0] m_axis_tdata,
  // ready_res[0]
  output logic                       m_axis_tuser
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_PUSH,
    S_WAIT,
    S_CHECK,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  logic [mfri_pkg::PSUM_W-1:0]  price_sum;
  logic [mfri_pkg::VOL_W-1:0]   vol;
  logic [mfri_pkg::FLOW_W-1:0]  flow;
  logic [mfri_pkg::FLOW_W-1:0]  prev_flow;
  logic [mfri_pkg::INDEX_W-1:0] res_index;
  logic                         res_ready;

  mfri_pkg::win_req_t           win_req;
  mfri_pkg::win_status_t        win_stat;
  logic [mfri_pkg::SUM_W-1:0]   rising_sum, falling_sum;
  logic                         div_start, div_done;
  logic [mfri_pkg::INDEX_W-1:0] div_q;

  assign s_axis_tready = (state == S_IDLE) && !rst;

  always_comb begin
    win_req.valid   = (state == S_PUSH) && (flow != prev_flow);
    win_req.falling = (flow < prev_flow);
    div_start       = (state == S_CHECK) && win_stat.both_full;
  end

  mfri_window u_window (
    .clk         (clk),
    .rst         (rst),
    .req         (win_req),
    .flow        (flow),
    .status      (win_stat),
    .rising_sum  (rising_sum),
    .falling_sum (falling_sum)
  );

  mfri_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .p        (rising_sum),
    .n        (falling_sum),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      prev_flow     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_PUSH;
        end
        S_PUSH: begin
          prev_flow <= flow;
          state     <= win_req.valid ? S_WAIT : S_CHECK;
        end
        S_WAIT: begin
          if (win_stat.done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_ready <= win_stat.both_full;
          res_index <= '0;
          state     <= win_stat.both_full ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_done) begin
            res_index <= div_q;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= mfri_pkg::OUT_W'(res_index);
            m_axis_tuser  <= res_ready;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      price_sum <= mfri_pkg::PSUM_W'(s_axis_tdata[23:0]) +
                   mfri_pkg::PSUM_W'(s_axis_tdata[47:24]) +
                   mfri_pkg::PSUM_W'(s_axis_tdata[71:48]);
      vol       <= s_axis_tdata[103:72];
    end
    if (state == S_MUL) begin
      flow <= mfri_pkg::FLOW_W'(price_sum) * mfri_pkg::FLOW_W'(vol);
    end
  end

`ifndef NO_ASSERTIONS
  a_win_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    win_stat.done |-> (state == S_WAIT))
    else $error("window update finished outside the wait state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("quotient finished outside the divide state");

  a_index_needs_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser || (m_axis_tdata == '0)))
    else $error("non-zero index without full windows");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata <= mfri_pkg::OUT_W'(mfri_pkg::PCT_SCALE)))
    else $error("index above full scale");
`endif

endmodule
`default_nettype wire
